// ----- src/sal_pkg.sv -----
package sal_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths of the transactions
    localparam int LEN_W      = 16;
    localparam int ADDR_W     = 48;
    localparam int OUT_IDX_W  = 8;
    localparam int OUT_CNT_W  = 9;

    // Length a frame must have after reset
    localparam logic [LEN_W-1:0] RESET_LENGTH = 16'd60;

    // Result outcome codes
    typedef enum logic [1:0] {
        OUT_IGNORED = 2'd0,
        OUT_KNOWN   = 2'd1,
        OUT_ADDED   = 2'd2,
        OUT_FULL    = 2'd3
    } t_outcome;

    // Input transaction
    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [ADDR_W-1:0] source_address;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        t_outcome              outcome;
        logic [OUT_IDX_W-1:0]  entry_index;
        logic [OUT_CNT_W-1:0]  known_count;
    } t_out_item;

endpackage

// ----- src/sal_search.sv -----
module sal_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  sal_pkg::t_in_item             i_item,
    input  logic [sal_pkg::LEN_W-1:0]     i_req_len,
    output logic                          o_idle,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output sal_pkg::t_out_item            o_res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    localparam logic [sal_pkg::CNT_W-1:0] DEPTH_CNT = sal_pkg::CNT_W'(sal_pkg::TABLE_DEPTH);

    // Address table: one write port, one registered read port
    logic [sal_pkg::ADDR_W-1:0] r_mem [sal_pkg::TABLE_DEPTH];
    logic [sal_pkg::ADDR_W-1:0] r_rd_data;

    t_state                      r_state, n_state;
    logic [sal_pkg::CNT_W-1:0]   r_count, n_count;
    logic [sal_pkg::CNT_W-1:0]   r_ptr, n_ptr;
    logic [sal_pkg::IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic                        r_cmp_vld, n_cmp_vld;
    logic [sal_pkg::ADDR_W-1:0]  r_addr, n_addr;
    sal_pkg::t_out_item          r_res, n_res;

    logic                        rd_en;
    logic                        wr_en;
    logic                        hit;
    logic                        len_ok;

    // Shared comparator: one stored entry per cycle
    assign hit    = r_cmp_vld && (r_rd_data == r_addr);
    assign len_ok = (i_item.frame_length == i_req_len);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = r_cmp_vld;
        n_addr    = r_addr;
        n_res     = r_res;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr    = i_item.source_address;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    if (len_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        n_res.outcome     = sal_pkg::OUT_IGNORED;
                        n_res.entry_index = '0;
                        n_res.known_count = sal_pkg::OUT_CNT_W'(r_count);
                        n_state           = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_res.outcome     = sal_pkg::OUT_KNOWN;
                    n_res.entry_index = sal_pkg::OUT_IDX_W'(r_cmp_idx);
                    n_res.known_count = sal_pkg::OUT_CNT_W'(r_count);
                    n_state           = S_RESULT;
                end else if (r_ptr == r_count) begin
                    // every stored entry compared, no match
                    if (r_count == DEPTH_CNT) begin
                        n_res.outcome     = sal_pkg::OUT_FULL;
                        n_res.entry_index = '0;
                        n_res.known_count = sal_pkg::OUT_CNT_W'(r_count);
                    end else begin
                        wr_en             = 1'b1;
                        n_count           = r_count + 1'b1;
                        n_res.outcome     = sal_pkg::OUT_ADDED;
                        n_res.entry_index = sal_pkg::OUT_IDX_W'(r_count);
                        n_res.known_count = sal_pkg::OUT_CNT_W'(n_count);
                    end
                    n_state = S_RESULT;
                end else begin
                    // fetch next entry, compare it next cycle
                    rd_en     = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_cmp_idx = r_ptr[sal_pkg::IDX_W-1:0];
                    n_cmp_vld = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_addr    <= n_addr;
        r_res     <= n_res;
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[sal_pkg::IDX_W-1:0]] <= r_addr;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[sal_pkg::IDX_W-1:0]];
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_count))
        else $error("scan pointer past stored entries");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance entry count");

    a_added_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_res.outcome == sal_pkg::OUT_ADDED))
        |-> (sal_pkg::OUT_CNT_W'(r_res.entry_index) + 1'b1 == r_res.known_count))
        else $error("added entry index does not match count");

endmodule

// ----- src/source_address_learning_table.sv -----
// A frame of the wrong length goes straight to its result; otherwise one comparator
// walks the stored entries of the table memory one entry per cycle (a hit ends the
// walk early). Only one frame is in flight: the next frame is taken once the result
// moves to the output register, which waits while the output is stalled.
// Reset (synchronous, active low): entry count cleared, required length back to 60;
// table contents are not cleared, as only entries below the count are ever read.
module source_address_learning_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // frame input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sal_pkg::t_in_item         i_in_item,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sal_pkg::t_out_item        o_out_item,
    // required length register
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sal_pkg::LEN_W-1:0] i_cfg_data
);

    logic [sal_pkg::LEN_W-1:0] r_req_len;
    logic                      r_out_valid;
    sal_pkg::t_out_item        r_out_item;

    logic                      idle;
    logic                      res_valid;
    logic                      res_take;
    logic                      in_take;
    sal_pkg::t_out_item        res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !idle;
    assign in_take     = i_in_valid && idle;

    // Output slot free or being emptied this cycle
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    sal_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_take),
        .i_item      (i_in_item),
        .i_req_len   (r_req_len),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // Required length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_len <= sal_pkg::RESET_LENGTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_req_len <= i_cfg_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
